/* rtl/etrd_pkg.sv */
// Shared types, codes and constants of the escaped trace record deframer.
// No dependencies; the design files but etrd_in_reg refer to it by scoped names, the testbench imports it.
package etrd_pkg;

    // Framing constants
    localparam int HEADER_BYTES = 12;
    localparam int HDR_IDX_W    = 4;
    localparam logic [7:0]  FLAG_BYTE    = 8'hFF;
    localparam logic [7:0]  ESC_BYTE     = 8'hFE;
    localparam logic [7:0]  ESC_OFFSET   = 8'd2;
    localparam logic [15:0] ATM_CELL_LEN = 16'd53;
    localparam logic [HDR_IDX_W-1:0] HDR_LAST_IDX = HDR_IDX_W'(HEADER_BYTES - 1);

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_LENGTH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ATM_CODE   = 2'd1;
    localparam logic [15:0] MAX_LENGTH_RESET = 16'hFFFF;
    localparam logic [6:0]  ATM_CODE_RESET   = 7'd3;

    // Stream widths: tdata carries every result field but kind and last, padded to bytes
    localparam int OUT_FIELDS_W = 8 + 24 + 40 + 8 + 1 + 7 + 16 + 2;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_HEAD = 2'd1,
        PH_LOAD = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_ERROR   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_FLAG     = 2'd1,
        ERR_ATM_LEN  = 2'd2,
        ERR_TOO_LONG = 2'd3
    } err_t;

    // One result item as it leaves the decoder
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data_byte;
        logic        last;
        logic [23:0] micros;
        logic [39:0] seconds;
        logic [7:0]  channel_number;
        logic        sender;
        logic [6:0]  protocol;
        logic [15:0] length;
        logic [1:0]  error_code;
    } result_t;

    // Configuration values seen by the decoder
    typedef struct packed {
        logic [15:0] max_length;
        logic [6:0]  atm_protocol_code;
    } cfg_t;

endpackage

/* rtl/escaped_trace_record_deframer.sv */
// Escaped trace record deframer, top level.
// Throughput: one raw byte per cycle while the result side keeps m_tready high.
// A result travels from the input register, where its accepted byte is held,
// through the decoder into the result register, which drives m_tvalid.
// Reset (rst_n low, asynchronous): hunting for a flag, both stages empty,
// max_length 65535 and atm_protocol_code 3.
module escaped_trace_record_deframer
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [7:0]                           s_tdata,   // [7:0] data_in
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [7:0] data_byte, [31:8] micros, [71:32] seconds, [79:72] channel_number,
    // [80] sender, [87:81] protocol, [103:88] length, [105:104] error_code
    output logic [etrd_pkg::OUT_TDATA_W-1:0]     m_tdata,
    output logic [1:0]                           m_tuser,   // [1:0] kind
    output logic                                 m_tlast,   // last
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [etrd_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [etrd_pkg::CFG_DATA_W-1:0]      cfg_data
);

    etrd_pkg::cfg_t    cfg_reg;
    logic              byte_valid;
    logic [7:0]        byte_data;
    logic              byte_take;
    logic              res_valid;
    logic              res_ready;
    etrd_pkg::result_t res;

    // Configuration registers; writes always accepted
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_length        <= etrd_pkg::MAX_LENGTH_RESET;
            cfg_reg.atm_protocol_code <= etrd_pkg::ATM_CODE_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                etrd_pkg::CFG_MAX_LENGTH: cfg_reg.max_length        <= cfg_data;
                etrd_pkg::CFG_ATM_CODE:   cfg_reg.atm_protocol_code <= cfg_data[6:0];
                default:                  ;
            endcase
        end
    end

    etrd_in_reg u_in_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .byte_valid (byte_valid),
        .byte_data  (byte_data),
        .byte_take  (byte_take)
    );

    etrd_decode u_decode
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .byte_valid (byte_valid),
        .byte_data  (byte_data),
        .byte_take  (byte_take),
        .res_ready  (res_ready),
        .res_valid  (res_valid),
        .res        (res)
    );

    etrd_out_reg u_out_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .res_valid  (res_valid),
        .res        (res),
        .res_ready  (res_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

/* rtl/etrd_in_reg.sv */
// Input register stage of the deframer: holds one raw byte for the decoder.
// Depends on etrd_pkg only through the caller; plain byte stream here.
module etrd_in_reg
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,     // [7:0] data_in
    output logic       byte_valid,
    output logic [7:0] byte_data,
    input  logic       byte_take
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;

    // Room when empty or when the held byte leaves this cycle
    assign s_tready = !valid_reg || byte_take;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_tready)
        begin
            valid_next = s_tvalid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            data_reg <= s_tdata;
        end
    end

    assign byte_valid = valid_reg;
    assign byte_data  = data_reg;

endmodule

/* rtl/etrd_decode.sv */
// Decoder of the deframer: flag hunt, unescape, header collection and checks,
// payload counting. Uses etrd_pkg types and constants.
module etrd_decode
(
    input  logic             clk,
    input  logic             rst_n,
    input  etrd_pkg::cfg_t   cfg,
    input  logic             byte_valid,
    input  logic [7:0]       byte_data,
    output logic             byte_take,
    input  logic             res_ready,
    output logic             res_valid,
    output etrd_pkg::result_t res
);

    etrd_pkg::phase_t phase_reg, phase_next;
    logic             esc_reg, esc_next;
    logic [etrd_pkg::HDR_IDX_W-1:0] count_reg, count_next;
    logic [15:0]      remain_reg, remain_next;
    logic [7:0]       hdr_mem [etrd_pkg::HEADER_BYTES];

    logic             hdr_we;
    logic [7:0]       value;
    logic             have_value;
    logic [15:0]      remain_dec;
    logic [15:0]      hdr_len;
    logic [6:0]       hdr_proto;

    // A byte is processed only when the result register can take its result
    assign byte_take = byte_valid && res_ready;

    assign remain_dec = remain_reg - 16'd1;
    assign hdr_len    = {hdr_mem[10], value};
    assign hdr_proto  = hdr_mem[9][7:1];

    // Unescape the current byte
    always_comb
    begin
        value      = byte_data;
        have_value = 1'b0;
        if (esc_reg)
        begin
            value      = byte_data + etrd_pkg::ESC_OFFSET;
            have_value = 1'b1;
        end
        else if (byte_data != etrd_pkg::FLAG_BYTE && byte_data != etrd_pkg::ESC_BYTE)
        begin
            have_value = 1'b1;
        end
    end

    // Next state and result
    always_comb
    begin
        phase_next  = phase_reg;
        esc_next    = esc_reg;
        count_next  = count_reg;
        remain_next = remain_reg;
        hdr_we      = 1'b0;
        res_valid   = 1'b0;
        res         = '0;
        if (byte_take)
        begin
            case (phase_reg)
                etrd_pkg::PH_HEAD, etrd_pkg::PH_LOAD:
                begin
                    if (esc_reg)
                    begin
                        esc_next = 1'b0;
                    end
                    else if (byte_data == etrd_pkg::FLAG_BYTE)
                    begin
                        // flag inside a record restarts header collection
                        phase_next     = etrd_pkg::PH_HEAD;
                        count_next     = '0;
                        res_valid      = 1'b1;
                        res.kind       = etrd_pkg::KIND_ERROR;
                        res.error_code = etrd_pkg::ERR_FLAG;
                    end
                    else if (byte_data == etrd_pkg::ESC_BYTE)
                    begin
                        esc_next = 1'b1;
                    end

                    if (have_value && phase_reg == etrd_pkg::PH_HEAD)
                    begin
                        hdr_we = 1'b1;
                        if (count_reg == etrd_pkg::HDR_LAST_IDX)
                        begin
                            // header complete: check and report
                            phase_next = etrd_pkg::PH_HUNT;
                            count_next = '0;
                            res_valid  = 1'b1;
                            if (hdr_proto == cfg.atm_protocol_code &&
                                hdr_len != etrd_pkg::ATM_CELL_LEN)
                            begin
                                res.kind       = etrd_pkg::KIND_ERROR;
                                res.error_code = etrd_pkg::ERR_ATM_LEN;
                            end
                            else if (hdr_len > cfg.max_length)
                            begin
                                res.kind       = etrd_pkg::KIND_ERROR;
                                res.error_code = etrd_pkg::ERR_TOO_LONG;
                            end
                            else
                            begin
                                res.kind           = etrd_pkg::KIND_HEADER;
                                res.last           = (hdr_len == 16'd0);
                                res.micros         = {hdr_mem[0], hdr_mem[1], hdr_mem[2]};
                                res.seconds        = {hdr_mem[3], hdr_mem[4], hdr_mem[5],
                                                      hdr_mem[6], hdr_mem[7]};
                                res.channel_number = hdr_mem[8];
                                res.sender         = hdr_mem[9][0];
                                res.protocol       = hdr_proto;
                                res.length         = hdr_len;
                                if (hdr_len != 16'd0)
                                begin
                                    phase_next  = etrd_pkg::PH_LOAD;
                                    remain_next = hdr_len;
                                end
                            end
                        end
                        else
                        begin
                            count_next = count_reg + 1'b1;
                        end
                    end
                    else if (have_value)
                    begin
                        // payload byte
                        remain_next   = remain_dec;
                        res_valid     = 1'b1;
                        res.kind      = etrd_pkg::KIND_PAYLOAD;
                        res.data_byte = value;
                        if (remain_dec == 16'd0)
                        begin
                            res.last   = 1'b1;
                            phase_next = etrd_pkg::PH_HUNT;
                        end
                    end
                end
                default:
                begin
                    // hunting, also for the unused phase code
                    phase_next = etrd_pkg::PH_HUNT;
                    if (byte_data == etrd_pkg::FLAG_BYTE)
                    begin
                        phase_next = etrd_pkg::PH_HEAD;
                        esc_next   = 1'b0;
                        count_next = '0;
                    end
                end
            endcase
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= etrd_pkg::PH_HUNT;
            esc_reg    <= 1'b0;
            count_reg  <= '0;
            remain_reg <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            esc_reg    <= esc_next;
            count_reg  <= count_next;
            remain_reg <= remain_next;
        end
    end

    // Header byte store
    always_ff @(posedge clk)
    begin
        if (hdr_we)
        begin
            hdr_mem[count_reg] <= value;
        end
    end

endmodule

/* rtl/etrd_out_reg.sv */
// Result register of the deframer: holds one result and drives the master stream.
// Uses etrd_pkg result type and widths.
module etrd_out_reg
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             res_valid,
    input  etrd_pkg::result_t                res,
    output logic                             res_ready,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // data_byte, micros, seconds, channel_number, sender, protocol, length,
    // error_code, zero pad
    output logic [etrd_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic [1:0]                       m_tuser,   // [1:0] kind
    output logic                             m_tlast    // last
);

    logic              valid_reg;
    logic              valid_next;
    etrd_pkg::result_t res_reg;

    // Free when empty or when the held result is taken this cycle
    assign res_ready = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (res_ready)
        begin
            valid_next = res_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            res_reg <= res;
        end
    end

    // Stream packing, first field lowest
    assign m_tvalid = valid_reg;
    assign m_tuser  = res_reg.kind;
    assign m_tlast  = res_reg.last;
    assign m_tdata  = {{(etrd_pkg::OUT_TDATA_W - etrd_pkg::OUT_FIELDS_W){1'b0}},
                       res_reg.error_code, res_reg.length, res_reg.protocol,
                       res_reg.sender, res_reg.channel_number, res_reg.seconds,
                       res_reg.micros, res_reg.data_byte};

endmodule

/* test/escaped_trace_record_deframer_tb.sv */
// Self-checking testbench for the escaped trace record deframer.
// Depends on rtl/etrd_pkg.sv and rtl/escaped_trace_record_deframer.sv; a queue-fed
// driver, a random-ready sink and an in-bench deframer predictor check every result.
module escaped_trace_record_deframer_tb;
    import etrd_pkg::*;

    localparam int CLK_PERIOD     = 4;
    localparam int RESET_CYCLES   = 6;
    localparam int SETTLE_CYCLES  = 8;       // a result passes the input and result registers
    localparam int DRAIN_LIMIT    = 50000;
    localparam int LONG_HOLD      = 400;
    localparam int TIMEOUT_CYCLES = 400000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [7:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [1:0] m_tuser;
    logic m_tlast;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    escaped_trace_record_deframer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Stream bytes waiting to be offered, and results the predictor expects
    logic [7:0] raw_bytes[$];
    result_t pending_results[$];
    int mismatches = 0;

    // Predictor state and its copy of the registers
    phase_t rx_phase = PH_HUNT;
    bit esc_armed = 1'b0;
    int hdr_fill = 0;
    logic [7:0] hdr_buf [HEADER_BYTES];
    logic [15:0] payload_left = '0;
    logic [15:0] max_len = MAX_LENGTH_RESET;
    logic [6:0] atm_code = ATM_CODE_RESET;

    // Stimulus and handshake control
    bit in_taken = 1'b0;
    bit src_calm = 1'b0;
    bit snk_calm = 1'b0;
    int src_gap = 0;
    int snk_hold = 0;
    bit long_hold_ask = 1'b0;
    bit long_hold_used = 1'b0;
    bit cont_record = 1'b0;
    bit escape_every = 1'b0;

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    task automatic open_record();
        rx_phase = PH_HEAD;
        esc_armed = 1'b0;
        hdr_fill = 0;
    endtask

    task automatic deframe_byte(input logic [7:0] b);
        logic [7:0] v;
        logic [15:0] len;
        logic [6:0] proto;
        result_t r;
        r = '0;
        // Hunting: only a flag matters
        if (rx_phase != PH_HEAD && rx_phase != PH_LOAD)
        begin
            rx_phase = PH_HUNT;
            if (b == FLAG_BYTE)
                open_record();
            return;
        end
        // Unescape; a raw flag restarts the record and reports it
        if (esc_armed)
        begin
            esc_armed = 1'b0;
            v = b + ESC_OFFSET;
        end
        else if (b == FLAG_BYTE)
        begin
            open_record();
            r.kind = KIND_ERROR;
            r.error_code = ERR_FLAG;
            pending_results.push_back(r);
            return;
        end
        else if (b == ESC_BYTE)
        begin
            esc_armed = 1'b1;
            return;
        end
        else
            v = b;

        if (rx_phase == PH_HEAD)
        begin
            hdr_buf[hdr_fill] = v;
            hdr_fill++;
            if (hdr_fill < HEADER_BYTES)
                return;
            // Header complete: decode and check
            len = {hdr_buf[10], hdr_buf[11]};
            proto = hdr_buf[9][7:1];
            rx_phase = PH_HUNT;
            esc_armed = 1'b0;
            hdr_fill = 0;
            if (proto == atm_code && len != ATM_CELL_LEN)
            begin
                r.kind = KIND_ERROR;
                r.error_code = ERR_ATM_LEN;
            end
            else if (len > max_len)
            begin
                r.kind = KIND_ERROR;
                r.error_code = ERR_TOO_LONG;
            end
            else
            begin
                r.kind = KIND_HEADER;
                r.last = (len == 16'd0);
                r.micros = {hdr_buf[0], hdr_buf[1], hdr_buf[2]};
                r.seconds = {hdr_buf[3], hdr_buf[4], hdr_buf[5], hdr_buf[6], hdr_buf[7]};
                r.channel_number = hdr_buf[8];
                r.sender = hdr_buf[9][0];
                r.protocol = proto;
                r.length = len;
                if (len != 16'd0)
                begin
                    rx_phase = PH_LOAD;
                    payload_left = len;
                end
            end
            pending_results.push_back(r);
        end
        else
        begin
            r.kind = KIND_PAYLOAD;
            r.data_byte = v;
            payload_left = payload_left - 16'd1;
            if (payload_left == 16'd0)
            begin
                r.last = 1'b1;
                rx_phase = PH_HUNT;
            end
            pending_results.push_back(r);
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
        end
    endtask

    // ------------------------------------------------------------------
    // Sampling at the rising edge: predict accepted bytes, check results
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : scoreboard_b
        result_t got;
        result_t want;
        if (rst_n && s_tvalid && s_tready)
            deframe_byte(s_tdata);
        if (rst_n && m_tvalid && m_tready)
        begin
            got.kind = m_tuser;
            got.last = m_tlast;
            got.data_byte = m_tdata[7:0];
            got.micros = m_tdata[31:8];
            got.seconds = m_tdata[71:32];
            got.channel_number = m_tdata[79:72];
            got.sender = m_tdata[80];
            got.protocol = m_tdata[87:81];
            got.length = m_tdata[103:88];
            got.error_code = m_tdata[105:104];
            if (pending_results.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result, kind %h tdata %h", $time, m_tuser, m_tdata);
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("kind", 64'(want.kind), 64'(got.kind));
                check_field("data_byte", 64'(want.data_byte), 64'(got.data_byte));
                check_field("last", 64'(want.last), 64'(got.last));
                check_field("micros", 64'(want.micros), 64'(got.micros));
                check_field("seconds", 64'(want.seconds), 64'(got.seconds));
                check_field("channel_number", 64'(want.channel_number),
                            64'(got.channel_number));
                check_field("sender", 64'(want.sender), 64'(got.sender));
                check_field("protocol", 64'(want.protocol), 64'(got.protocol));
                check_field("length", 64'(want.length), 64'(got.length));
                check_field("error_code", 64'(want.error_code), 64'(got.error_code));
            end
        end
        in_taken <= rst_n && s_tvalid && s_tready;
    end

    // Mostly short gaps, a few long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(99);
        if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------
    // Input driver: one request per byte, changes at the falling edge
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || in_taken)
        begin
            if ($urandom_range(199) == 0)
                src_calm <= !src_calm;
            if (src_gap > 0)
            begin
                src_gap <= src_gap - 1;
                s_tvalid <= 1'b0;
            end
            else if (raw_bytes.size() > 0)
            begin
                s_tdata <= raw_bytes.pop_front();
                s_tvalid <= 1'b1;
                src_gap <= (src_calm || $urandom_range(99) < 60) ? 0 : gap_len();
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Result sink: random ready, with one long hold-off on request
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if ($urandom_range(199) == 0)
            snk_calm <= !snk_calm;
        if (!rst_n)
            m_tready <= 1'b0;
        else if (long_hold_ask && !long_hold_used)
        begin
            long_hold_used <= 1'b1;
            snk_hold <= LONG_HOLD;
            m_tready <= 1'b0;
        end
        else if (snk_hold > 0)
        begin
            snk_hold <= snk_hold - 1;
            m_tready <= 1'b0;
        end
        else if (snk_calm || $urandom_range(99) < 75)
            m_tready <= 1'b1;
        else
        begin
            snk_hold <= gap_len() - 1;
            m_tready <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        // Request taken at this edge
        case (idx)
            CFG_MAX_LENGTH: max_len = val;
            CFG_ATM_CODE:   atm_code = val[6:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Flag and escape bytes always go escaped; others too while escape_every is set, else now and then
    task automatic put_escaped(input logic [7:0] v);
        if (v == FLAG_BYTE || v == ESC_BYTE || escape_every || $urandom_range(15) == 0)
        begin
            raw_bytes.push_back(ESC_BYTE);
            raw_bytes.push_back(v - ESC_OFFSET);
        end
        else
            raw_bytes.push_back(v);
    endtask

    // One record; cut >= 0 replaces the body byte at that position by a raw flag and ends the record there
    task automatic send_record(input logic [23:0] us, input logic [39:0] sec,
                               input logic [7:0] chan, input logic snd,
                               input logic [6:0] proto, input logic [15:0] len,
                               input logic [7:0] pl[$], input int cut, input bit lead);
        logic [95:0] hdr_v;
        logic [7:0] body[$];
        hdr_v = {us, sec, chan, proto, snd, len};
        for (int i = 0; i < HEADER_BYTES; i++)
            body.push_back(hdr_v[95 - 8 * i -: 8]);
        foreach (pl[i])
            body.push_back(pl[i]);
        if (lead)
            raw_bytes.push_back(FLAG_BYTE);
        foreach (body[i])
        begin
            if (i == cut)
            begin
                raw_bytes.push_back(FLAG_BYTE);
                return;
            end
            put_escaped(body[i]);
        end
    endtask

    task automatic rand_record();
        logic [15:0] len;
        logic [6:0] proto;
        logic [7:0] pl[$];
        int r;
        int cut;
        bit ok;
        r = $urandom_range(99);
        proto = ($urandom_range(3) == 0) ? atm_code : 7'($urandom);
        if (r < 10)
            len = 16'd0;
        else if (r < 65)
            len = 16'($urandom_range(1, 12));
        else if (r < 82)
            len = 16'($urandom_range(13, 64));
        else if (r < 90)
        begin
            len = ATM_CELL_LEN;
            proto = atm_code;
        end
        else if (max_len >= 16'd1000)
            len = 16'($urandom_range(100, 300));
        else if (r < 95)
            len = max_len + 16'($urandom_range(0, 1));
        else
            len = 16'($urandom);
        ok = !(proto == atm_code && len != ATM_CELL_LEN) && len <= max_len;
        if (ok)
            repeat (len) pl.push_back(8'($urandom));
        cut = ($urandom_range(99) < 8) ? $urandom_range(0, 11 + pl.size()) : -1;
        // Hunting noise between records
        if (!cont_record && $urandom_range(99) < 15)
            repeat ($urandom_range(1, 5)) raw_bytes.push_back(8'($urandom));
        send_record(24'($urandom), {8'($urandom), 32'($urandom)}, 8'($urandom), 1'($urandom),
                    proto, len, pl, cut, !cont_record);
        cont_record = (cut >= 0);
    endtask

    task automatic fill_random(input int n);
        while (raw_bytes.size() < n)
            rand_record();
    endtask

    // Wait until every byte is taken and every result has come, then settle
    task automatic wait_drain();
        int n;
        n = 0;
        while ((raw_bytes.size() != 0 || s_tvalid || pending_results.size() != 0)
               && n < DRAIN_LIMIT)
        begin
            @(posedge clk);
            n++;
        end
        if (n >= DRAIN_LIMIT)
        begin
            mismatches++;
            $display("%0t: %0d expected results never arrived", $time, pending_results.size());
            pending_results.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        logic [7:0] pl[$];
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: noise while hunting, extremes, escapes, empty record
        raw_bytes.push_back(8'h00);
        raw_bytes.push_back(ESC_BYTE);
        raw_bytes.push_back(8'h7F);
        raw_bytes.push_back(8'h80);
        pl = '{8'hFF, 8'hFE};
        send_record('1, '1, '1, 1'b1, 7'h7F, 16'd2, pl, -1, 1'b1);
        // Bytes after an escape that are themselves flag and escape codes
        escape_every = 1'b1;
        pl = '{8'h01, 8'h00, 8'h80};
        send_record(24'h000001, 40'h0, 8'h01, 1'b0, 7'h01, 16'd3, pl, -1, 1'b1);
        escape_every = 1'b0;
        pl.delete();
        send_record('0, '0, '0, 1'b0, 7'h00, 16'd0, pl, -1, 1'b1);
        send_record('0, '0, '0, 1'b0, ATM_CODE_RESET, 16'd52, pl, -1, 1'b1);
        // Flag inside the header, then inside the payload; each starts a new record
        send_record(24'h123456, 40'h0, 8'h02, 1'b1, 7'h05, 16'd1, pl, 5, 1'b1);
        pl = '{8'h5A};
        send_record(24'h654321, 40'h1, 8'h03, 1'b0, 7'h06, 16'd1, pl, -1, 1'b0);
        pl = '{8'h11, 8'h22, 8'h33};
        send_record(24'h0, 40'h2, 8'h1E, 1'b1, 7'h07, 16'd3, pl, 13, 1'b1);
        send_record(24'h0, 40'h3, 8'h1F, 1'b0, 7'h08, 16'd3, pl, -1, 1'b0);
        wait_drain();

        // Reset values written back; the sink holds off once for a long stretch
        write_reg(CFG_MAX_LENGTH, 16'hFFFF);
        write_reg(CFG_ATM_CODE, 16'd3);
        long_hold_ask = 1'b1;
        fill_random(300);
        wait_drain();

        // Smallest limits: ATM check ahead of the length check
        cont_record = 1'b0;
        write_reg(CFG_MAX_LENGTH, 16'd0);
        write_reg(CFG_ATM_CODE, 16'd0);
        pl.delete();
        send_record(24'h0, 40'h0, 8'h0, 1'b0, 7'h00, 16'd1, pl, -1, 1'b1);
        send_record(24'h0, 40'h0, 8'h0, 1'b0, 7'h00, ATM_CELL_LEN, pl, -1, 1'b1);
        fill_random(200);
        wait_drain();

        cont_record = 1'b0;
        write_reg(CFG_MAX_LENGTH, 16'd40);
        write_reg(CFG_ATM_CODE, 16'd127);
        fill_random(300);
        wait_drain();

        // Indexes past the register list are ignored; then random settings
        cont_record = 1'b0;
        write_reg(CFG_INDEX_W'(2), 16'($urandom));
        write_reg(CFG_INDEX_W'(3), 16'($urandom));
        write_reg(CFG_MAX_LENGTH, 16'($urandom_range(20, 300)));
        write_reg(CFG_ATM_CODE, 16'($urandom_range(0, 127)));
        fill_random(300);
        wait_drain();

        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
